### src/hrfp_pkg.sv
`timescale 1ns / 1ps

package hrfp_pkg;

    // Field and register widths
    localparam int LENGTH_BITS = 16;
    localparam int MP_BITS     = 13;
    localparam int SEQ_BITS    = 16;
    localparam int SUM_W       = ((LENGTH_BITS > MP_BITS) ? LENGTH_BITS : MP_BITS) + 1;

    // Payload limits
    localparam logic [MP_BITS-1:0] MIN_PAYLOAD   = 13'd16;
    localparam logic [MP_BITS-1:0] MP_RESET      = 13'd1400;
    localparam logic [MP_BITS-1:0] FU_HDR_BYTES  = 13'd3;

    // FU indicator byte (type 49 shifted into the NAL header position)
    localparam logic [7:0] FU_TYPE_BYTE  = 8'h62;
    localparam logic [5:0] NAL_TYPE_MASK = 6'h3F;
    localparam logic [7:0] FU_END_BIT    = 8'h40;
    localparam logic [7:0] FU_START_BIT  = 8'h80;

    // NAL header capture progress
    localparam logic [1:0] HDR_NONE  = 2'd0;
    localparam logic [1:0] HDR_TYPE  = 2'd1;
    localparam logic [1:0] HDR_DONE  = 2'd2;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // One classified byte, ready to be expanded into output beats
    typedef struct packed {
        logic [7:0]          data;
        logic                hdr;
        logic [7:0]          layer;
        logic [7:0]          fu;
        logic                first;
        logic                last;
        logic [SEQ_BITS-1:0] seq;
        logic                marker;
        logic                start;
    } entry_t;

    typedef struct packed {
        logic [SEQ_BITS-1:0] seq;
    } front_status_t;

    typedef struct packed {
        logic [FIFO_AW:0] count;
        logic             full;
        logic             empty;
    } fifo_status_t;

    typedef struct packed {
        logic [1:0] beat_idx;
    } back_status_t;

endpackage

### src/h265_rtp_fu_packetizer.sv
`timescale 1ns / 1ps

// H.265 RTP payload packetizer with FU fragmentation. NAL bytes enter one per
// beat on in_valid/in_ready; the first beat of a NAL carries its length,
// start code length, frame-start flag and marker request. A NAL that fits in
// max_payload (cfg_we/cfg_wdata, reset 1400, values below 16 act as 16) goes
// out unchanged as one packet; a larger one is cut into FU packets, each
// opened by the FU indicator, the layer byte and the FU header. The block
// takes one input beat per cycle while the queue has room and gives one
// output beat per cycle while out_ready is high; the output side sets the
// sustained rate: each FU packet's first data byte follows its header beats,
// and the two NAL header bytes of a fragmented NAL give no output. A
// four-entry queue between the classifying front and the beat-expanding back
// absorbs these differences and feeds accepted bytes to the output register.
module h265_rtp_fu_packetizer
    import hrfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [12:0]  cfg_wdata,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   nal_byte,
    input  logic         first_of_nal,
    input  logic [15:0]  nal_length,
    input  logic [2:0]   start_code_length,
    input  logic         frame_start,
    input  logic         marker_request,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   out_byte,
    output logic         packet_first,
    output logic         packet_last,
    output logic [15:0]  sequence_number,
    output logic         marker_bit,
    output logic         start_flag
);

    logic          push, pop;
    entry_t        push_entry, head;
    front_status_t front_stat;
    fifo_status_t  fifo_stat;
    back_status_t  back_stat;

    hrfp_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .nal_byte          (nal_byte),
        .first_of_nal      (first_of_nal),
        .nal_length        (nal_length),
        .start_code_length (start_code_length),
        .frame_start       (frame_start),
        .marker_request    (marker_request),
        .q_full            (fifo_stat.full),
        .push              (push),
        .push_entry        (push_entry),
        .status            (front_stat)
    );

    hrfp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (fifo_stat)
    );

    hrfp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .q_empty         (fifo_stat.empty),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .packet_first    (packet_first),
        .packet_last     (packet_last),
        .sequence_number (sequence_number),
        .marker_bit      (marker_bit),
        .start_flag      (start_flag),
        .status          (back_stat)
    );

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fifo_stat.full)
        else $error("queue overflow");

    // A header run in progress always has its entry still queued
    a_hdr_run_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (back_stat.beat_idx != 2'd0) |-> !fifo_stat.empty)
        else $error("header run without queued entry");

    // The sequence number advances by at most one per cycle
    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (front_stat.seq == $past(front_stat.seq)) ||
                 (front_stat.seq == $past(front_stat.seq) + 16'd1))
        else $error("sequence number jumped");

    // Occupancy stays within the queue depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_stat.count <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count out of range");

endmodule

### src/hrfp_front.sv
`timescale 1ns / 1ps

module hrfp_front
    import hrfp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [MP_BITS-1:0]  cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          nal_byte,
    input  logic                first_of_nal,
    input  logic [15:0]         nal_length,
    input  logic [2:0]          start_code_length,
    input  logic                frame_start,
    input  logic                marker_request,
    input  logic                q_full,
    output logic                push,
    output entry_t              push_entry,
    output front_status_t       status
);

    logic [MP_BITS-1:0]     mp_reg;
    logic [SEQ_BITS-1:0]    seq_reg, seq_next;
    logic                   frag_reg, frag_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic [MP_BITS-1:0]     bip_reg, bip_next;
    logic [1:0]             hidx_reg, hidx_next;
    logic [7:0]             layer_reg, layer_next;
    logic [5:0]             type_reg, type_next;
    logic                   ffp_reg, ffp_next;
    logic                   marker_reg, marker_next;
    logic                   fs_reg, fs_next;

    logic [LENGTH_BITS-1:0] len_in, rem_eff, rem_dec;
    logic [MP_BITS-1:0]     mp, cap, bip_eff;
    logic [MP_BITS:0]       bip_inc;
    logic [1:0]             hidx_eff;
    logic                   frag_eff, ffp_eff, marker_eff, fs_eff;
    logic                   oversize, final_pkt, last, emit, accept;
    logic [7:0]             fu;

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign status.seq = seq_reg;

    // Classify the byte and work out the next state
    always_comb
    begin
        len_in   = LENGTH_BITS'(nal_length);
        mp       = (mp_reg < MIN_PAYLOAD) ? MIN_PAYLOAD : mp_reg;
        cap      = mp - FU_HDR_BYTES;
        oversize = (SUM_W'(len_in) + SUM_W'(start_code_length)) > SUM_W'(mp);

        rem_eff    = first_of_nal ? len_in            : rem_reg;
        bip_eff    = first_of_nal ? '0                : bip_reg;
        hidx_eff   = first_of_nal ? HDR_NONE          : hidx_reg;
        marker_eff = first_of_nal ? marker_request    : marker_reg;
        fs_eff     = first_of_nal ? frame_start       : fs_reg;
        frag_eff   = first_of_nal ? oversize          : frag_reg;
        ffp_eff    = first_of_nal ? oversize          : ffp_reg;

        rem_dec   = rem_eff - 1'b1;
        bip_inc   = {1'b0, bip_eff} + 1'b1;
        final_pkt = (SUM_W'(rem_eff) + SUM_W'(bip_eff)) <= SUM_W'(cap);

        seq_next    = seq_reg;
        frag_next   = frag_eff;
        rem_next    = rem_eff;
        bip_next    = bip_eff;
        hidx_next   = hidx_eff;
        layer_next  = layer_reg;
        type_next   = type_reg;
        ffp_next    = ffp_eff;
        marker_next = marker_eff;
        fs_next     = fs_eff;

        emit       = 1'b0;
        last       = 1'b0;
        fu         = '0;
        push_entry = '0;
        push_entry.data   = nal_byte;
        push_entry.layer  = layer_reg;
        push_entry.seq    = seq_reg;

        if (rem_eff != '0)
        begin
            if (!frag_eff)
            begin
                // Single packet: pass the byte through
                last              = (rem_eff == LENGTH_BITS'(1));
                emit              = 1'b1;
                push_entry.first  = (bip_eff == '0);
                push_entry.last   = last;
                push_entry.marker = marker_eff;
                push_entry.start  = fs_eff;
                rem_next          = rem_dec;
                bip_next          = last ? '0 : bip_inc[MP_BITS-1:0];
                if (last)
                begin
                    seq_next = seq_reg + 1'b1;
                end
            end
            else if (hidx_eff == HDR_NONE)
            begin
                // Capture the NAL type
                type_next = nal_byte[6:1] & NAL_TYPE_MASK;
                hidx_next = HDR_TYPE;
                rem_next  = rem_dec;
            end
            else if (hidx_eff == HDR_TYPE)
            begin
                // Capture the layer byte
                layer_next = nal_byte;
                hidx_next  = HDR_DONE;
                rem_next   = rem_dec;
            end
            else
            begin
                // Fragment data byte, with the FU header ahead of the first
                fu = {2'b00, type_reg & NAL_TYPE_MASK};
                if (final_pkt)
                begin
                    fu = fu | FU_END_BIT;
                end
                else if (ffp_eff)
                begin
                    fu = fu | FU_START_BIT;
                end
                if (bip_eff == '0)
                begin
                    ffp_next = 1'b0;
                end
                last              = (bip_inc >= {1'b0, cap}) || (rem_dec == '0);
                emit              = 1'b1;
                push_entry.hdr    = (bip_eff == '0);
                push_entry.fu     = fu;
                push_entry.last   = last;
                push_entry.marker = final_pkt && marker_eff;
                rem_next          = rem_dec;
                bip_next          = last ? '0 : bip_inc[MP_BITS-1:0];
                if (last)
                begin
                    seq_next = seq_reg + 1'b1;
                end
            end
        end
    end

    assign push = accept && emit;

    // Hold configuration and per-NAL state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mp_reg     <= MP_RESET;
            seq_reg    <= '0;
            frag_reg   <= 1'b0;
            rem_reg    <= '0;
            bip_reg    <= '0;
            hidx_reg   <= HDR_NONE;
            layer_reg  <= '0;
            type_reg   <= '0;
            ffp_reg    <= 1'b0;
            marker_reg <= 1'b0;
            fs_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mp_reg <= cfg_wdata;
            end
            if (accept)
            begin
                seq_reg    <= seq_next;
                frag_reg   <= frag_next;
                rem_reg    <= rem_next;
                bip_reg    <= bip_next;
                hidx_reg   <= hidx_next;
                layer_reg  <= layer_next;
                type_reg   <= type_next;
                ffp_reg    <= ffp_next;
                marker_reg <= marker_next;
                fs_reg     <= fs_next;
            end
        end
    end

endmodule

### src/hrfp_fifo.sv
`timescale 1ns / 1ps

module hrfp_fifo
    import hrfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  entry_t       push_entry,
    input  logic         pop,
    output entry_t       head,
    output fifo_status_t status
);

    entry_t             mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic               do_push, do_pop;

    assign status.count = count_reg;
    assign status.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem[rd_ptr_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### src/hrfp_back.sv
`timescale 1ns / 1ps

module hrfp_back
    import hrfp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  entry_t              head,
    input  logic                q_empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                packet_first,
    output logic                packet_last,
    output logic [15:0]         sequence_number,
    output logic                marker_bit,
    output logic                start_flag,
    output back_status_t        status
);

    localparam logic [1:0] BEAT_IND   = 2'd0;
    localparam logic [1:0] BEAT_LAYER = 2'd1;
    localparam logic [1:0] BEAT_FU    = 2'd2;
    localparam logic [1:0] BEAT_DATA  = 2'd3;

    logic [1:0]  idx_reg;
    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic        first_reg, last_reg, marker_reg, start_reg;
    logic [15:0] seq_reg;

    logic [7:0]  beat_byte;
    logic        beat_first, beat_last, beat_final, load;

    assign status.beat_idx = idx_reg;
    assign load            = !q_empty && (!valid_reg || out_ready);
    assign pop             = load && beat_final;

    // Pick the beat of the head entry
    always_comb
    begin
        beat_byte  = head.data;
        beat_first = head.first;
        beat_last  = head.last;
        beat_final = 1'b1;
        if (head.hdr)
        begin
            case (idx_reg)
                BEAT_IND:
                begin
                    beat_byte  = FU_TYPE_BYTE;
                    beat_first = 1'b1;
                    beat_last  = 1'b0;
                    beat_final = 1'b0;
                end
                BEAT_LAYER:
                begin
                    beat_byte  = head.layer;
                    beat_first = 1'b0;
                    beat_last  = 1'b0;
                    beat_final = 1'b0;
                end
                BEAT_FU:
                begin
                    beat_byte  = head.fu;
                    beat_first = 1'b0;
                    beat_last  = 1'b0;
                    beat_final = 1'b0;
                end
                BEAT_DATA:
                begin
                    beat_byte  = head.data;
                    beat_first = 1'b0;
                    beat_last  = head.last;
                    beat_final = 1'b1;
                end
                default:
                begin
                    beat_byte  = head.data;
                    beat_first = 1'b0;
                    beat_last  = head.last;
                    beat_final = 1'b1;
                end
            endcase
        end
    end

    // Hold the output beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= BEAT_IND;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= beat_final ? BEAT_IND : idx_reg + 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= beat_byte;
            first_reg  <= beat_first;
            last_reg   <= beat_last;
            seq_reg    <= head.seq;
            marker_reg <= head.marker;
            start_reg  <= head.start;
        end
    end

    assign out_valid       = valid_reg;
    assign out_byte        = byte_reg;
    assign packet_first    = first_reg;
    assign packet_last     = last_reg;
    assign sequence_number = seq_reg;
    assign marker_bit      = marker_reg;
    assign start_flag      = start_reg;

endmodule
